// File: rtl/ifd_pkg.sv
package ifd_pkg;

  // defaults for the top-level parameters
  localparam int unsigned DEPTH_DEF       = 4096;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  // fixed field and register widths
  localparam int unsigned DELAY_BITS    = 21;
  localparam int unsigned LEN_BITS      = 13;
  localparam int unsigned GAIN_BITS     = 16;
  localparam int unsigned GAIN_FRAC     = 15;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_GAIN = 2'd1;

  localparam logic [LEN_BITS-1:0] LINE_LENGTH_RST = 13'd4096;
  localparam int unsigned         LEN_MIN         = 2;

  // step enables from the sequencer to the arithmetic
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic fb_en;
  } ifd_ctrl_t;

endpackage

// File: rtl/interpolated_feedback_delay_unit.sv
// Takes one input item at a time; no new item is accepted until the
// previous one is written back. A sequencer walks each item through
// clamp, address, two-port store read, interpolate, feedback and write-back.
// The result register lets the next item enter while a result waits.
// Reset: async, active low; then a clearing pass zeroes the
// delay store, with s_axis_tready low until it ends. Config writes between items.
module interpolated_feedback_delay_unit #(
  parameter int unsigned DEPTH       = ifd_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = ifd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = ifd_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // input stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: in_sample, delay_time (from bit 0 up), zero padded to bytes
  input  logic [((SAMPLE_BITS+ifd_pkg::DELAY_BITS+7)/8)*8-1:0] s_axis_tdata,
  // output stream
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: out_sample, zero padded to bytes
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [ifd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [ifd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);
  import ifd_pkg::*;

  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = AW + 1;                        // holds DEPTH
  localparam int unsigned CW = (LEN_BITS > LW) ? LEN_BITS : LW;
  localparam int unsigned DW = ((DELAY_BITS > LW + F) ? DELAY_BITS : LW + F) + 1;
  localparam int unsigned OW = ((S + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PREP, ST_CLAMP, ST_ADDR, ST_MUL, ST_ADD, ST_FB
  } state_e;
  // the write-back step has no room in the full 3-bit state encoding, so
  // it is kept in its own register, wb_q, typed by the enum below
  typedef enum logic {
    WB_OFF, WB_ON
  } wb_e;

  state_e state_q;
  wb_e    wb_q;

  // configuration registers
  logic [LEN_BITS-1:0]         line_length_q;
  logic signed [GAIN_BITS-1:0] gain_q;

  // per-item registers
  logic [S-1:0]          x_q;
  logic [DELAY_BITS-1:0] dt_raw_q;
  logic [DW-1:0]         dt_q;
  logic [LW-1:0]         len_q;
  logic [AW-1:0]         pos_q;     // write position
  logic [F-1:0]          frac_q;
  logic [AW-1:0]         clr_q;

  // result register
  logic          m_valid_q;
  logic [OW-1:0] m_data_q;

  // combinational
  logic [CW-1:0] len_ext;
  logic [CW-1:0] len_c;
  logic [DW-1:0] span;
  logic [DW-1:0] dt_ext;
  logic [DW-1:0] pos_sh;
  logic [DW-1:0] rp;
  logic [LW-1:0] idx_w;
  logic [LW-1:0] len_m1;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] idx_b;
  logic          out_free;
  logic          s_accept;
  logic          wr_go;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [S-1:0]  mem_wdata;
  logic          mem_re;
  logic [S-1:0]  rd_a;
  logic [S-1:0]  rd_b;
  logic [S-1:0]  y;
  logic [S-1:0]  w;
  ifd_ctrl_t     ctrl;

  assign s_axis_tready = (state_q == ST_IDLE) && (wb_q == WB_OFF);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign wr_go         = (wb_q == WB_ON) && out_free;

  // effective line length: clamped to [2, DEPTH]
  always_comb begin
    len_ext = CW'(line_length_q);
    if (len_ext < CW'(LEN_MIN)) begin
      len_c = CW'(LEN_MIN);
    end else if (len_ext > CW'(DEPTH)) begin
      len_c = CW'(DEPTH);
    end else begin
      len_c = len_ext;
    end
  end

  assign span   = DW'(len_q) << F;
  assign dt_ext = DW'(dt_raw_q);
  assign pos_sh = DW'(pos_q) << F;
  assign len_m1 = len_q - LW'(1);

  // read position, behind the write position with wrap
  always_comb begin
    if (pos_sh >= dt_q) begin
      rp = pos_sh - dt_q;
    end else begin
      rp = pos_sh + span - dt_q;
    end
    idx_w = rp[F +: LW];
    if (idx_w >= len_q) begin
      idx_w = len_m1;
    end
    idx_a = idx_w[AW-1:0];
    idx_b = (idx_w == len_m1) ? '0 : AW'(idx_w + LW'(1));
  end

  // store access
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = w;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (wr_go) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = (state_q == ST_ADDR);

  assign ctrl.mul_en = (state_q == ST_MUL);
  assign ctrl.add_en = (state_q == ST_ADD);
  assign ctrl.fb_en  = (state_q == ST_FB);

  ifd_store #(
    .DEPTH      (DEPTH),
    .SAMPLE_BITS(S)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .re_i     (mem_re),
    .raddr_a_i(idx_a),
    .raddr_b_i(idx_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  ifd_interp #(
    .SAMPLE_BITS(S),
    .FRAC_BITS  (F)
  ) u_interp (
    .clk_i (clk_i),
    .ctrl_i(ctrl),
    .rd_a_i(rd_a),
    .rd_b_i(rd_b),
    .frac_i(frac_q),
    .x_i   (x_q),
    .gain_i(gain_q),
    .y_o   (y),
    .w_o   (w)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= LINE_LENGTH_RST;
      gain_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LINE_LENGTH:   line_length_q <= cfg_wdata_i[LEN_BITS-1:0];
        REG_FEEDBACK_GAIN: gain_q        <= $signed(cfg_wdata_i[GAIN_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      x_q      <= s_axis_tdata[S-1:0];
      dt_raw_q <= s_axis_tdata[S +: DELAY_BITS];
    end
    if (state_q == ST_CLAMP) begin
      dt_q <= (dt_ext > span) ? span : dt_ext;
    end
    if (state_q == ST_ADDR) begin
      frac_q <= rp[F-1:0];
    end
  end

  // sequencer, write position and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      wb_q      <= WB_OFF;
      clr_q     <= '0;
      len_q     <= LW'(DEPTH);
      pos_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (wr_go) begin
        // write-back of the fed-back sample and hand-off of the result
        wb_q      <= WB_OFF;
        pos_q     <= (LW'(pos_q) == len_m1) ? '0 : pos_q + AW'(1);
        m_valid_q <= 1'b1;
        m_data_q  <= OW'(y);
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_accept) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          len_q   <= LW'(len_c);
          state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          // line shortened under the write position: restart at zero
          if (LW'(pos_q) >= len_q) begin
            pos_q <= '0;
          end
          state_q <= ST_ADDR;
        end
        ST_ADDR: state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_ADD;
        ST_ADD:  state_q <= ST_FB;
        ST_FB: begin
          wb_q    <= WB_ON;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: rtl/ifd_store.sv
module ifd_store #(
  parameter int unsigned DEPTH       = ifd_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = ifd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [SAMPLE_BITS-1:0]   wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [SAMPLE_BITS-1:0]   rdata_a_o,
  output logic [SAMPLE_BITS-1:0]   rdata_b_o
);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// File: rtl/ifd_interp.sv
module ifd_interp #(
  parameter int unsigned SAMPLE_BITS = ifd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = ifd_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  ifd_pkg::ifd_ctrl_t                   ctrl_i,
  input  logic [SAMPLE_BITS-1:0]               rd_a_i,
  input  logic [SAMPLE_BITS-1:0]               rd_b_i,
  input  logic [FRAC_BITS-1:0]                 frac_i,
  input  logic [SAMPLE_BITS-1:0]               x_i,
  input  logic signed [ifd_pkg::GAIN_BITS-1:0] gain_i,
  output logic [SAMPLE_BITS-1:0]               y_o,
  output logic [SAMPLE_BITS-1:0]               w_o
);
  import ifd_pkg::*;

  localparam int unsigned S = SAMPLE_BITS;

  logic signed [S:0]               diff;
  logic signed [S+FRAC_BITS+1:0]   prod_q;
  logic signed [S+FRAC_BITS+1:0]   prod_sh;
  logic signed [S+1:0]             y_sum;
  logic [S-1:0]                    y_q;
  logic signed [S+GAIN_BITS-1:0]   fbp_q;
  logic signed [S+GAIN_BITS-1:0]   fb_sh;
  logic signed [S+1:0]             w_sum;
  logic                            w_ok;

  assign diff    = $signed({rd_b_i[S-1], rd_b_i}) - $signed({rd_a_i[S-1], rd_a_i});
  // arithmetic shift gives the floor
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign y_sum   = $signed({{2{rd_a_i[S-1]}}, rd_a_i}) + $signed(prod_sh[S+1:0]);

  assign fb_sh   = fbp_q >>> GAIN_FRAC;
  assign w_sum   = $signed({{2{x_i[S-1]}}, x_i}) + $signed(fb_sh[S+1:0]);
  assign w_ok    = (&w_sum[S+1:S-1]) || !(|w_sum[S+1:S-1]);

  always_comb begin
    if (w_ok) begin
      w_o = w_sum[S-1:0];
    end else if (w_sum[S+1]) begin
      w_o = {1'b1, {(S-1){1'b0}}};
    end else begin
      w_o = {1'b0, {(S-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= diff * $signed({1'b0, frac_i});
    end
    if (ctrl_i.add_en) begin
      y_q <= y_sum[S-1:0];
    end
    if (ctrl_i.fb_en) begin
      fbp_q <= $signed(y_q) * gain_i;
    end
  end

  assign y_o = y_q;

endmodule

// File: rtl/ifd_checker.sv
module ifd_checker #(
  parameter int unsigned DEPTH       = ifd_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = ifd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = ifd_pkg::FRAC_BITS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [((SAMPLE_BITS+ifd_pkg::DELAY_BITS+7)/8)*8-1:0] s_axis_tdata,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic                               cfg_we_i,
  input logic [ifd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input logic [ifd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  logic s_acc;
  logic unused_ok;

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign unused_ok = ^{s_axis_tdata, cfg_we_i, cfg_index_i, cfg_wdata_i,
                       DEPTH[0], FRAC_BITS[0]};

  // nothing is taken or offered once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !s_axis_tready && !m_axis_tvalid)
    else $error("ready or valid during reset");

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("second item taken while one is in flight");

  // a result never appears right after an item is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind interpolated_feedback_delay_unit ifd_checker #(
  .DEPTH      (DEPTH),
  .SAMPLE_BITS(SAMPLE_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_ifd_checker (.*);

// File: sim/testbench.sv
module testbench;
  import ifd_pkg::*;

  // Store and field sizes as the block is built here
  localparam int unsigned STORE_DEPTH = DEPTH_DEF;
  localparam int unsigned FRAC        = FRAC_BITS_DEF;
  localparam int unsigned IN_W        = ((SAMPLE_BITS_DEF + DELAY_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W       = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int unsigned PAD_W       = IN_W - SAMPLE_BITS_DEF - DELAY_BITS;

  // Register slots the block does not decode; writes there must change nothing
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  // Long receiver hold-off: starts after these result counts, lasts this many cycles
  localparam int HOLD_AT_A   = 150;
  localparam int HOLD_AT_B   = 480;
  localparam int HOLD_CYCLES = 300;

  // Quiet time after the last result
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic signed [15:0] in_sample;
    logic [DELAY_BITS-1:0] delay_time;
  } audio_item_t;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;   // in_sample, delay_time, zero pad (from bit 0 up)
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;         // out_sample (from bit 0 up)

  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i = '0;

  interpolated_feedback_delay_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Items waiting to go out, and predicted delayed samples waiting to come back
  audio_item_t        audio_items_q[$];
  logic signed [15:0] delayed_q[$];
  int                 mismatches = 0;

  // Shadow of the delay line: store, write index and both registers
  logic signed [15:0]  line_mem [STORE_DEPTH];
  int unsigned         wr_pos;
  logic [LEN_BITS-1:0] len_reg;
  logic signed [15:0]  gain_reg;

  // Effective line length the stimulus is shaped for
  int unsigned cur_len = STORE_DEPTH;

  // One step of the flanger: read two neighbors behind the write index,
  // blend them, then write input plus scaled output back (saturated).
  function automatic logic signed [15:0] flange_step(input logic signed [15:0] x,
                                                     input logic [DELAY_BITS-1:0] dt_in);
    int unsigned       len, pos, idx, nxt, fr;
    longint unsigned   span, dt, rp;
    longint            a, b, y, w;
    len = len_reg;
    if (len < LEN_MIN) len = LEN_MIN;
    if (len > STORE_DEPTH) len = STORE_DEPTH;
    // shortened line: a stale write index restarts at 0
    pos = (wr_pos >= len) ? 0 : wr_pos;
    span = longint'(len) << FRAC;
    dt = dt_in;
    if (dt > span) dt = span;
    if ((longint'(pos) << FRAC) >= dt) rp = (longint'(pos) << FRAC) - dt;
    else rp = (longint'(pos) << FRAC) + span - dt;
    idx = 32'(rp >> FRAC);
    if (idx >= len) idx = len - 1;
    fr  = 32'(rp & ((1 << FRAC) - 1));
    nxt = (idx != len - 1) ? idx + 1 : 0;
    a = line_mem[idx];
    b = line_mem[nxt];
    y = a + (((b - a) * longint'(fr)) >>> FRAC);
    w = longint'(x) + ((y * longint'(gain_reg)) >>> GAIN_FRAC);
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    line_mem[pos] = w[15:0];
    wr_pos = (pos != len - 1) ? pos + 1 : 0;
    return y[15:0];
  endfunction

  // Driver: bursts of random length, random gaps in between; a gap of zero
  // chains bursts into long stretches with no idle cycles.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive
    audio_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (audio_items_q.size() != 0) begin
        it = audio_items_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, it.delay_time, it.in_sample};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: the stall pattern is redrawn at random periodically; twice it holds off for
  // a long stretch so the block backs up and drops s_axis_tready.
  rx_mode_e rx_mode   = RX_OPEN;
  int       rx_cyc    = 0;
  int       taken     = 0;
  int       hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode       <= RX_OPEN;
      rx_cyc        <= 0;
      taken         <= 0;
      hold_left     <= 0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (rx_cyc % 50 == 49) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      if (m_axis_tvalid && m_axis_tready) taken <= taken + 1;
      if (m_axis_tvalid && m_axis_tready && (taken == HOLD_AT_A || taken == HOLD_AT_B)) begin
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:     m_axis_tready <= 1'b1;
          RX_HALF:     m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 4) == 0);
          RX_PERIODIC: m_axis_tready <= (rx_cyc % 7 != 3);
          default:     m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  // Monitor: tracks register writes, predicts on each accepted input item,
  // and checks each accepted result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [15:0] want;
    if (!rst_ni) begin
      for (int k = 0; k < STORE_DEPTH; k++) line_mem[k] = '0;
      wr_pos   = 0;
      len_reg  = LINE_LENGTH_RST;
      gain_reg = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LINE_LENGTH:   len_reg  = cfg_wdata_i[LEN_BITS-1:0];
          REG_FEEDBACK_GAIN: gain_reg = cfg_wdata_i[GAIN_BITS-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        delayed_q.push_back(flange_step(s_axis_tdata[15:0],
                                        s_axis_tdata[16 +: DELAY_BITS]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (delayed_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: out_sample %0d",
                                        $signed(m_axis_tdata[15:0]));
          mismatches++;
        end else begin
          want = delayed_q.pop_front();
          if (m_axis_tdata[15:0] !== want) begin
            if (mismatches < 10) $display("out_sample mismatch: expected %0d, got %0d",
                                          want, $signed(m_axis_tdata[15:0]));
            mismatches++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Line length write; also tracks the effective length for stimulus ranges
  task automatic set_line(input logic [CFG_DATA_BITS-1:0] v);
    int unsigned l;
    l = v[LEN_BITS-1:0];
    if (l < LEN_MIN) l = LEN_MIN;
    if (l > STORE_DEPTH) l = STORE_DEPTH;
    cur_len = l;
    write_reg(REG_LINE_LENGTH, v);
  endtask

  task automatic push_item(input logic signed [15:0] smp, input logic [DELAY_BITS-1:0] dl);
    audio_item_t it;
    it.in_sample  = smp;
    it.delay_time = dl;
    audio_items_q.push_back(it);
  endtask

  // Block is idle once all items went in and every result came back;
  // checked between edges so the driver's and monitor's updates have landed
  task automatic drain();
    while (audio_items_q.size() != 0 || s_axis_tvalid || delayed_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly in-range delays with random fractions; some whole-sample delays,
  // the full line, and raw 21-bit values that get clamped.
  task automatic queue_random(input int n);
    logic signed [15:0]    smp;
    logic [DELAY_BITS-1:0] dl;
    int unsigned           span;
    span = cur_len << FRAC;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0:       smp = 16'sh7FFF;
        1:       smp = 16'sh8000;
        2:       smp = 16'($urandom_range(0, 63) - 32);
        default: smp = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       dl = DELAY_BITS'($urandom);
        1:       dl = DELAY_BITS'($urandom_range(0, cur_len) << FRAC);
        2:       dl = DELAY_BITS'(span);
        default: dl = DELAY_BITS'($urandom_range(0, span));
      endcase
      push_item(smp, dl);
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_BITS-1:0] v;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: full 4096 line, no feedback. Field extremes; max
    // delay code is clamped to the line.
    push_item(16'sh7FFF, '0);
    push_item(16'sh8000, {DELAY_BITS{1'b1}});
    push_item(16'sh0001, 21'd1048576);
    push_item(-16'sd1,   21'd1048575);
    push_item(16'sd12345, 21'd256);
    drain();

    // Length 0 acts as 2; write index 5 is now past the line so it restarts
    // at 0. Gain -1.0 with full-scale samples drives write-back saturation.
    set_line(16'd0);
    write_reg(REG_FEEDBACK_GAIN, 16'h8000);
    push_item(16'sh7FFF, 21'd0);
    push_item(16'sh8000, 21'd0);
    push_item(16'sh7FFF, 21'd128);
    push_item(16'sh8000, 21'd512);
    push_item(16'sd100,  {DELAY_BITS{1'b1}});
    push_item(16'sh7FFF, 21'd1);
    push_item(16'sh8000, 21'd255);
    drain();

    // Length above the store acts as 4096; max positive gain
    set_line(16'h1FFF);
    write_reg(REG_FEEDBACK_GAIN, 16'h7FFF);
    push_item(16'sh7FFF, 21'd768);
    push_item(16'sh8000, 21'd1048576);
    push_item(16'sd2000, 21'd1048577);
    push_item(16'sh7FFF, 21'd300);
    drain();

    // Three-entry line, half gain, fractional reads across the wrap; writes
    // to undecoded slots must not disturb anything
    set_line(16'd3);
    write_reg(REG_FEEDBACK_GAIN, 16'h4000);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0001);
    push_item(16'sd30000, 21'd0);
    push_item(-16'sd30000, 21'd64);
    push_item(16'sd1000, 21'd192);
    push_item(16'sh7FFF, 21'd767);
    push_item(16'sh8000, 21'd768);
    push_item(16'sd5, 21'd383);
    drain();

    // Length 1 also acts as 2; upper data bits beyond the register are junk
    set_line(16'hE001);
    push_item(16'sd7, 21'd0);
    push_item(-16'sd7, 21'd100);
    push_item(16'sd9, 21'd511);
    drain();

    // Random part: a new setting per phase, mostly short lines so the
    // store fills and feedback builds up
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 9))
        0:       v = CFG_DATA_BITS'($urandom_range(0, 1));
        1:       v = CFG_DATA_BITS'(STORE_DEPTH);
        2:       v = CFG_DATA_BITS'($urandom_range(STORE_DEPTH + 1, (1 << LEN_BITS) - 1));
        3:       v = {3'($urandom), 13'($urandom_range(2, 40))};
        default: v = CFG_DATA_BITS'($urandom_range(2, 80));
      endcase
      set_line(v);
      case ($urandom_range(0, 5))
        0:       v = 16'h7FFF;
        1:       v = 16'h8000;
        2:       v = 16'h0000;
        default: v = CFG_DATA_BITS'($urandom);
      endcase
      write_reg(REG_FEEDBACK_GAIN, v);
      queue_random(65);
      drain();
    end

    if (mismatches == 0 && delayed_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the clearing pass plus the slowest legal run
  initial begin
    #4800000;
    $display("status: fail");
    $finish;
  end

endmodule
